/* sv/vct_pkg.sv */
package vct_pkg;

  localparam int ClockW    = 64;
  localparam int IndexW    = 4;
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    CmdIncrement = 2'd0,
    CmdMerge     = 2'd1,
    CmdCompare   = 2'd2,
    CmdRead      = 2'd3
  } vct_cmd_e;

  typedef enum logic [1:0] {
    OrdEqual       = 2'd0,
    OrdDominates   = 2'd1,
    OrdDominatedBy = 2'd2,
    OrdConcurrent  = 2'd3
  } vct_order_e;

  typedef struct packed {
    vct_cmd_e            command;
    logic [IndexW-1:0]   drive_index;
    logic [ClockW-1:0]   clock_value;
    logic                last;
  } vct_in_t;

  typedef struct packed {
    logic [ClockW-1:0]   clock_out;
    vct_order_e          ordering;
    logic                ordering_valid;
  } vct_out_t;

  typedef struct packed {
    vct_cmd_e            command;
    logic [IndexW-1:0]   drive_index;
    logic [ClockW-1:0]   clock_value;
    logic                last;
    logic                in_range;
  } vct_op_t;

endpackage

/* sv/vector_clock_table.sv */
// a beat passes the command queue and back stage, and is registered in the result queue
// throughput: one beat per cycle while the result queue has room, set by the single
// back-stage read-modify-write of the table; two-entry queues on each side absorb stalls
// reset: asynchronous, clears both queues, the nonzero and seen masks and the
// compare flags; table entries read as zero until written, so no clearing pass
module vector_clock_table #(
  parameter int NUM_DRIVES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vct_pkg::vct_in_t  item_i,
  input  logic              push,
  output logic              full,
  output vct_pkg::vct_out_t result_o,
  output logic              empty,
  input  logic              pop
);
  import vct_pkg::*;

  vct_op_t  op;
  vct_out_t res;
  logic     op_empty, op_pop;
  logic     res_push, res_full;

  vct_front #(
    .NUM_DRIVES(NUM_DRIVES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .push_i     (push),
    .full_o     (full),
    .op_o       (op),
    .op_empty_o (op_empty),
    .op_pop_i   (op_pop)
  );

  vct_back #(
    .NUM_DRIVES(NUM_DRIVES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .op_valid_i (!op_empty),
    .op_pop_o   (op_pop),
    .res_o      (res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  vct_fifo #(
    .Width($bits(vct_out_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

  a_back_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full && !op_empty)
    else $error("back stage fired without room or work");

  a_accept_reaches_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> !op_empty)
    else $error("accepted beat missing from command queue");

  a_order_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push && res.ordering_valid |-> op.command == CmdCompare && op.last)
    else $error("ordering reported outside a final compare beat");

  a_order_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push && !res.ordering_valid |-> res.ordering == OrdEqual)
    else $error("ordering nonzero without a finished compare");

endmodule

/* sv/vct_fifo.sv */
module vct_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  import vct_pkg::*;

  logic [Width-1:0]    mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                wr_en, rd_en;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (wr_en) begin
      wr_d = (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (rd_en) begin
      rd_d = (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* sv/vct_front.sv */
module vct_front #(
  parameter int NUM_DRIVES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vct_pkg::vct_in_t item_i,
  input  logic             push_i,
  output logic             full_o,
  output vct_pkg::vct_op_t op_o,
  output logic             op_empty_o,
  input  logic             op_pop_i
);
  import vct_pkg::*;

  vct_op_t op_in;

  // classify: flag indexes that fall outside the table
  always_comb begin
    op_in.command     = item_i.command;
    op_in.drive_index = item_i.drive_index;
    op_in.clock_value = item_i.clock_value;
    op_in.last        = item_i.last;
    op_in.in_range    = (int'(item_i.drive_index) < NUM_DRIVES);
  end

  vct_fifo #(
    .Width($bits(vct_op_t))
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (op_in),
    .full_o  (full_o),
    .pop_i   (op_pop_i),
    .data_o  (op_o),
    .empty_o (op_empty_o)
  );

endmodule

/* sv/vct_back.sv */
module vct_back #(
  parameter int NUM_DRIVES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vct_pkg::vct_op_t  op_i,
  input  logic              op_valid_i,
  output logic              op_pop_o,
  output vct_pkg::vct_out_t res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);
  import vct_pkg::*;

  localparam int TableDepth = (NUM_DRIVES < 16) ? NUM_DRIVES : 16;
  localparam int TabIdxW    = $clog2(TableDepth);

  logic [ClockW-1:0]     table_q [TableDepth];
  logic [TableDepth-1:0] nonzero_q, nonzero_d;
  logic [TableDepth-1:0] seen_q, seen_d;
  logic                  own_greater_q, own_greater_d;
  logic                  other_greater_q, other_greater_d;

  logic [TabIdxW-1:0]    tidx;
  logic [TableDepth-1:0] hot;
  logic [TableDepth-1:0] seen_upd;
  logic [ClockW-1:0]     own;
  logic [ClockW-1:0]     wr_val;
  logic                  wr_en;
  logic                  own_gt, oth_gt;
  logic                  own_acc, oth_acc, own_fin;
  logic                  fire, is_last_cmp;

  assign tidx       = op_i.drive_index[TabIdxW-1:0];
  assign hot        = TableDepth'(1) << tidx;
  assign fire       = op_valid_i && !res_full_i;
  assign op_pop_o   = fire;
  assign res_push_o = fire;

  always_comb begin
    // an entry with its nonzero bit clear reads as zero
    own = '0;
    if (op_i.in_range && nonzero_q[tidx]) begin
      own = table_q[tidx];
    end
    own_gt = (own > op_i.clock_value);
    oth_gt = (op_i.clock_value > own);

    wr_en  = 1'b0;
    wr_val = own;
    case (op_i.command)
      CmdIncrement: begin
        wr_en  = op_i.in_range;
        wr_val = own + ClockW'(1);
      end
      CmdMerge: begin
        wr_en  = op_i.in_range && oth_gt;
        wr_val = op_i.clock_value;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase

    is_last_cmp = (op_i.command == CmdCompare) && op_i.last;
    seen_upd    = seen_q | (op_i.in_range ? hot : '0);
    own_acc     = own_greater_q | own_gt;
    oth_acc     = other_greater_q | oth_gt;
    own_fin     = own_acc | (|(nonzero_q & ~seen_upd));

    res_o.clock_out      = wr_en ? wr_val : own;
    res_o.ordering_valid = is_last_cmp;
    res_o.ordering       = is_last_cmp ? vct_order_e'({oth_acc, own_fin}) : OrdEqual;

    nonzero_d       = nonzero_q;
    seen_d          = seen_q;
    own_greater_d   = own_greater_q;
    other_greater_d = other_greater_q;
    if (fire) begin
      if (wr_en) begin
        nonzero_d = (wr_val != '0) ? (nonzero_q | hot) : (nonzero_q & ~hot);
      end
      if (op_i.command == CmdCompare) begin
        if (op_i.last) begin
          seen_d          = '0;
          own_greater_d   = 1'b0;
          other_greater_d = 1'b0;
        end else begin
          seen_d          = seen_upd;
          own_greater_d   = own_acc;
          other_greater_d = oth_acc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonzero_q       <= '0;
      seen_q          <= '0;
      own_greater_q   <= 1'b0;
      other_greater_q <= 1'b0;
    end else begin
      nonzero_q       <= nonzero_d;
      seen_q          <= seen_d;
      own_greater_q   <= own_greater_d;
      other_greater_q <= other_greater_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      table_q[tidx] <= wr_val;
    end
  end

endmodule

/* tb/sv/vector_clock_table_tb.sv */
`timescale 1ns / 100ps

module vector_clock_table_tb;
  import vct_pkg::*;

  localparam int NumDrives     = 16;
  localparam int RandomBeats   = 1100;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  vct_in_t  item_i;
  logic     push;
  logic     full;
  vct_out_t result_o;
  logic     empty;
  logic     pop;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req_seq;
  int beats_sent;
  int stall_cnt;

  class clock_scoreboard;
    logic [ClockW-1:0]    entries [NumDrives];
    logic [NumDrives-1:0] nonzero;
    logic [NumDrives-1:0] seen;
    bit                   own_gt;
    bit                   other_gt;
    vct_out_t             pending [$];
    int                   errors;
    int                   checked;
    int                   orders [4];

    function new();
      foreach (entries[i]) entries[i] = '0;
      nonzero  = '0;
      seen     = '0;
      own_gt   = 1'b0;
      other_gt = 1'b0;
      errors   = 0;
      checked  = 0;
      foreach (orders[i]) orders[i] = 0;
    endfunction

    function void write_entry(int idx, logic [ClockW-1:0] v);
      entries[idx] = v;
      nonzero[idx] = (v != '0);
    endfunction

    function void note_input(vct_in_t it);
      vct_out_t          exp;
      logic [ClockW-1:0] own;
      bit                ok;
      int                idx;
      idx = int'(it.drive_index);
      ok  = idx < NumDrives;
      own = ok ? entries[idx] : '0;
      exp = '0;
      case (it.command)
        CmdIncrement: begin
          if (ok) write_entry(idx, own + 1'b1);
        end
        CmdMerge: begin
          if (ok && it.clock_value > own) write_entry(idx, it.clock_value);
        end
        CmdCompare: begin
          if (own > it.clock_value) own_gt = 1'b1;
          else if (it.clock_value > own) other_gt = 1'b1;
          if (ok) seen[idx] = 1'b1;
          if (it.last) begin
            if ((nonzero & ~seen) != '0) own_gt = 1'b1;
            if (!own_gt && !other_gt) exp.ordering = OrdEqual;
            else if (own_gt && !other_gt) exp.ordering = OrdDominates;
            else if (!own_gt && other_gt) exp.ordering = OrdDominatedBy;
            else exp.ordering = OrdConcurrent;
            exp.ordering_valid = 1'b1;
            orders[exp.ordering]++;
            seen     = '0;
            own_gt   = 1'b0;
            other_gt = 1'b0;
          end
        end
        default: ;
      endcase
      exp.clock_out = ok ? entries[idx] : '0;
      pending.push_back(exp);
    endfunction

    function void check_result(vct_out_t got);
      vct_out_t exp;
      if (pending.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.clock_out !== exp.clock_out) begin
        $error("clock_out: expected %h, got %h", exp.clock_out, got.clock_out);
        errors++;
      end
      if (got.ordering !== exp.ordering) begin
        $error("ordering: expected %0d, got %0d", exp.ordering, got.ordering);
        errors++;
      end
      if (got.ordering_valid !== exp.ordering_valid) begin
        $error("ordering_valid: expected %0d, got %0d", exp.ordering_valid,
               got.ordering_valid);
        errors++;
      end
    endfunction
  endclass

  clock_scoreboard sb;

  vector_clock_table #(
    .NUM_DRIVES(NumDrives)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .push    (push),
    .full    (full),
    .result_o(result_o),
    .empty   (empty),
    .pop     (pop)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic offer_beat(input vct_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_input(it);
    beats_sent++;
  endtask

  task automatic send_cmd(input vct_cmd_e cmd, input int idx, input logic [ClockW-1:0] val,
                          input bit last);
    vct_in_t it;
    it.command     = cmd;
    it.drive_index = idx[IndexW-1:0];
    it.clock_value = val;
    it.last        = last;
    offer_beat(it);
  endtask

  function automatic logic [ClockW-1:0] rand_clock();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ClockW-1:0] pick_other_clock(int idx);
    logic [ClockW-1:0] own;
    int                r;
    own = sb.entries[idx];
    r   = $urandom_range(99);
    if (r < 70) return own;
    if (r < 80) return own + 1'b1;
    if (r < 90) return own - 1'b1;
    return rand_clock();
  endfunction

  task automatic table_update();
    int                idx;
    int                r;
    logic [ClockW-1:0] val;
    idx = $urandom_range(NumDrives - 1);
    r   = $urandom_range(99);
    if (r < 40) begin
      send_cmd(CmdIncrement, idx, rand_clock(), 1'($urandom_range(1)));
    end else if (r < 75) begin
      r = $urandom_range(99);
      if (r < 70) val = sb.entries[idx] + $urandom_range(3);
      else if (r < 85) val = rand_clock();
      else val = '1 - $urandom_range(2);
      send_cmd(CmdMerge, idx, val, 1'($urandom_range(1)));
    end else begin
      send_cmd(CmdRead, idx, rand_clock(), 1'($urandom_range(1)));
    end
  endtask

  // receiver side
  initial begin
    int holds_served;
    holds_served = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req_seq != holds_served) begin
        holds_served++;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(result_o);
      if ((push && !full) || (pop && !empty)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= WatchdogLimit) begin
        $display("watchdog: no beat moved for %0d cycles", stall_cnt);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int  order [NumDrives];
    int  k, j, tmp, n, r, done, kind;
    int  directed;
    bit  pressure_done;
    sb            = new();
    rst_ni        = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    item_i        = '0;
    send_idle_pct = 7;
    recv_idle_pct = 74;
    hold_req_seq  = 0;
    beats_sent    = 0;
    stall_cnt     = 0;
    pressure_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, wrap, merge no-op, each ordering, repeats, interleaving
    send_cmd(CmdRead,      0,  '0,  1'b0);
    send_cmd(CmdCompare,   0,  '0,  1'b1);
    send_cmd(CmdCompare,   7,  '1,  1'b1);
    send_cmd(CmdIncrement, 15, '0,  1'b0);
    send_cmd(CmdRead,      15, '1,  1'b1);
    send_cmd(CmdMerge,     3,  '1,  1'b0);
    send_cmd(CmdIncrement, 3,  '0,  1'b0);
    send_cmd(CmdRead,      3,  '0,  1'b0);
    send_cmd(CmdMerge,     5,  100, 1'b0);
    send_cmd(CmdMerge,     5,  50,  1'b0);
    send_cmd(CmdCompare,   5,  100, 1'b0);
    send_cmd(CmdCompare,   15, 1,   1'b1);
    send_cmd(CmdCompare,   5,  100, 1'b1);
    send_cmd(CmdCompare,   5,  200, 1'b0);
    send_cmd(CmdCompare,   15, 1,   1'b1);
    send_cmd(CmdCompare,   5,  50,  1'b0);
    send_cmd(CmdCompare,   15, 2,   1'b1);
    send_cmd(CmdCompare,   5,  100, 1'b0);
    send_cmd(CmdCompare,   5,  100, 1'b0);
    send_cmd(CmdCompare,   15, 1,   1'b1);
    send_cmd(CmdCompare,   5,  100, 1'b0);
    send_cmd(CmdIncrement, 15, '0,  1'b0);
    send_cmd(CmdCompare,   15, 2,   1'b1);
    send_cmd(CmdMerge,     0,  1,   1'b0);
    send_cmd(CmdCompare,   15, 2,   1'b1);
    directed = beats_sent;

    while (beats_sent - directed < RandomBeats) begin
      done = beats_sent - directed;
      if (done < RandomBeats / 3) begin
        send_idle_pct <= 7;
        recv_idle_pct <= 74;
      end else if (done < 2 * RandomBeats / 3) begin
        send_idle_pct <= 74;
        recv_idle_pct <= 7;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        if (!pressure_done && done >= 3 * RandomBeats / 4) begin
          hold_req_seq  <= hold_req_seq + 1;
          pressure_done = 1'b1;
        end
      end
      kind = $urandom_range(99);
      if (kind < 35) begin
        // whole vector streamed in shuffled order
        for (k = 0; k < NumDrives; k++) order[k] = k;
        for (k = NumDrives - 1; k > 0; k--) begin
          j        = $urandom_range(k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (k = 0; k < NumDrives; k++) begin
          if ($urandom_range(99) < 15) table_update();
          send_cmd(CmdCompare, order[k], pick_other_clock(order[k]), k == NumDrives - 1);
        end
      end else if (kind < 55) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          r = $urandom_range(NumDrives - 1);
          if ($urandom_range(99) < 10) table_update();
          send_cmd(CmdCompare, r, pick_other_clock(r), k == n - 1);
        end
      end else if (kind < 85) begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) table_update();
      end else begin
        send_cmd(vct_cmd_e'($urandom_range(3)), $urandom_range(15), rand_clock(),
                 1'($urandom_range(1)));
      end
    end
    push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run: %0d beats in, %0d results checked, %0d errors", beats_sent, sb.checked,
             sb.errors);
    $display("orderings: equal %0d, dominates %0d, dominated %0d, concurrent %0d",
             sb.orders[OrdEqual], sb.orders[OrdDominates], sb.orders[OrdDominatedBy],
             sb.orders[OrdConcurrent]);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
